// ----- design/stsc_pkg.sv -----
// ----------------------------------------------------------------------------
// stsc_pkg
// Shared types, codes and fixed-point helpers for the spherical sweep cell.
// ----------------------------------------------------------------------------
package stsc_pkg;

  typedef logic signed [47:0] fx_t;    // Q16.32 value
  typedef logic signed [49:0] opnd_t;  // operand of the arithmetic units
  typedef logic signed [51:0] acc_t;   // exact sum before saturation

  localparam fx_t FX_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam fx_t FX_MIN = 48'sh8000_0000_0000;

  localparam int CfgAddrWidth = 3;
  localparam int CfgDataWidth = 48;

  typedef enum logic [CfgAddrWidth-1:0] {
    CFG_QUAD_WEIGHT     = 3'd0,
    CFG_DIRECTION_COS   = 3'd1,
    CFG_ALPHA_UPPER     = 3'd2,
    CFG_ALPHA_LOWER     = 3'd3,
    CFG_CORRECTOR_TAU   = 3'd4,
    CFG_EDGE_FLUX_START = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic        [34:0] quad_weight;
    logic signed [33:0] direction_cosine;
    fx_t                alpha_upper;
    fx_t                alpha_lower;
    logic        [32:0] corrector_tau;
    fx_t                edge_flux_start;
  } cfg_t;

  // one queued cell, already classified
  typedef struct packed {
    logic        start_of_sweep;
    logic        cell_is_origin;
    logic        skip;            // zero cosine: no result
    logic [46:0] area_outer;
    logic [46:0] area_inner;
    fx_t         cell_source;
    fx_t         cell_total;
    fx_t         angle_half_in;
    fx_t         scalar_flux_in;
  } cell_t;

  // back-end operation sequence
  typedef enum logic [3:0] {
    ST_G    = 4'd0,   // g = (Ao-Ai)/w
    ST_M1   = 4'd1,   // |mu|*sum
    ST_M2   = 4'd2,   // m1*e
    ST_M3   = 4'd3,   // g*asum
    ST_M4   = 4'd4,   // m3*h
    ST_M5   = 4'd5,   // |mu|*Ar
    ST_M6   = 4'd6,   // g*aU
    ST_PSI  = 4'd7,   // num/den
    ST_M7   = 4'd8,   // w*psi
    ST_M8   = 4'd9,   // (1-tau)*h
    ST_HQ   = 4'd10   // (psi-m8)/tau
  } step_t;

  localparam int NumSteps = 11;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_WAIT,
    BK_FIN
  } bk_state_t;

  function automatic acc_t sx(input fx_t x);
    return {{4{x[47]}}, x};
  endfunction

  function automatic opnd_t wide(input fx_t x);
    return {{2{x[47]}}, x};
  endfunction

  function automatic fx_t sat_fx(input acc_t x);
    if (x[51:47] == 5'b00000 || x[51:47] == 5'b11111) begin
      return x[47:0];
    end
    return x[51] ? FX_MIN : FX_MAX;
  endfunction

  function automatic logic [48:0] mag(input opnd_t x);
    logic [49:0] t;
    t = x[49] ? 50'(-x) : 50'(x);
    return t[48:0];
  endfunction

  // signed result from magnitude, saturated
  function automatic fx_t mag_sat(input logic [65:0] q, input logic neg);
    if (neg) begin
      if (q > 66'h8000_0000_0000) begin
        return FX_MIN;
      end
      return ~q[47:0] + 48'd1;
    end
    if (q > 66'h7FFF_FFFF_FFFF) begin
      return FX_MAX;
    end
    return q[47:0];
  endfunction

endpackage

// ----- design/spherical_transport_sweep_cell_top.sv -----
// ----------------------------------------------------------------------------
// spherical_transport_sweep_cell_top
// One angle of a diamond-difference sweep over spherical shells.
// ----------------------------------------------------------------------------
// Each cell runs in turn through three divides (47 quotient steps each) and
//   eight multiplies; a divide that hits zero dividend, zero divisor or
//   overflow skips its quotient steps. One cell is worked on at a time, and
//   its result waits while an earlier result is still stalled at the output.
// Zero-cosine cells are popped with no result (edge seed still applied).
// Reset (rst, synchronous): queue empty, no result pending, edge flux zero,
//   registers w = 1.0, mu = 1.0, tau = 0.5, others zero.
// ----------------------------------------------------------------------------
module spherical_transport_sweep_cell_top (
  input  logic         clk,
  input  logic         rst,
  // cell input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [46:0] area_outer, [93:47] area_inner, [141:94] cell_source,
  // [189:142] cell_total, [237:190] angle_half_in, [285:238] scalar_flux_in
  input  logic [287:0] s_axis_tdata,
  // [0] start_of_sweep, [1] cell_is_origin
  input  logic [1:0]   s_axis_tuser,
  // result output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [47:0] angular_flux, [95:48] scalar_flux_out, [143:96] angle_half_out
  output logic [143:0] m_axis_tdata,
  // configuration writes
  input  logic         cfg_we,
  input  logic [stsc_pkg::CfgAddrWidth-1:0] cfg_addr,
  input  logic [stsc_pkg::CfgDataWidth-1:0] cfg_data
);

  stsc_pkg::cfg_t  cfg;
  logic            q_valid;
  logic            q_pop;
  stsc_pkg::cell_t q_item;

  // register file; the user must write it only while the block is idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.quad_weight      <= 35'h1_0000_0000;
      cfg.direction_cosine <= 34'sh1_0000_0000;
      cfg.alpha_upper      <= '0;
      cfg.alpha_lower      <= '0;
      cfg.corrector_tau    <= 33'h0_8000_0000;
      cfg.edge_flux_start  <= '0;
    end else if (cfg_we) begin
      case (stsc_pkg::cfg_idx_t'(cfg_addr))
        stsc_pkg::CFG_QUAD_WEIGHT:     cfg.quad_weight      <= cfg_data[34:0];
        stsc_pkg::CFG_DIRECTION_COS:   cfg.direction_cosine <= cfg_data[33:0];
        stsc_pkg::CFG_ALPHA_UPPER:     cfg.alpha_upper      <= cfg_data;
        stsc_pkg::CFG_ALPHA_LOWER:     cfg.alpha_lower      <= cfg_data;
        stsc_pkg::CFG_CORRECTOR_TAU:   cfg.corrector_tau    <= cfg_data[32:0];
        stsc_pkg::CFG_EDGE_FLUX_START: cfg.edge_flux_start  <= cfg_data;
        default: begin
          // unmapped index: ignored
        end
      endcase
    end
  end

  // front: accept, classify, two-entry queue
  stsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .mu            (cfg.direction_cosine),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // back: arithmetic sequencer, edge flux, result register
  stsc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- design/stsc_front.sv -----
// ----------------------------------------------------------------------------
// stsc_front
// Accepts cells, tags zero-cosine cells and queues them for the back end.
// ----------------------------------------------------------------------------
module stsc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [287:0]        s_axis_tdata,
  input  logic [1:0]          s_axis_tuser,
  input  logic signed [33:0]  mu,
  output logic                q_valid,
  output stsc_pkg::cell_t     q_item,
  input  logic                q_pop
);

  stsc_pkg::cell_t slot [0:1];
  stsc_pkg::cell_t in_cell;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            push;

  always_comb begin
    in_cell.start_of_sweep = s_axis_tuser[0];
    in_cell.cell_is_origin = s_axis_tuser[1];
    in_cell.skip           = (mu == 34'sd0);
    in_cell.area_outer     = s_axis_tdata[46:0];
    in_cell.area_inner     = s_axis_tdata[93:47];
    in_cell.cell_source    = s_axis_tdata[141:94];
    in_cell.cell_total     = s_axis_tdata[189:142];
    in_cell.angle_half_in  = s_axis_tdata[237:190];
    in_cell.scalar_flux_in = s_axis_tdata[285:238];
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid & s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign q_item        = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_cell;
    end
  end

endmodule

// ----- design/stsc_mul.sv -----
// ----------------------------------------------------------------------------
// stsc_mul
// Q16.32 multiplier: four 25x25 partial products, floor and saturate.
// ----------------------------------------------------------------------------
module stsc_mul (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  stsc_pkg::opnd_t a,
  input  stsc_pkg::opnd_t b,
  output logic            done,
  output stsc_pkg::fx_t   res
);

  logic [48:0] ua;
  logic [48:0] ub;
  logic        neg;
  logic        busy;
  logic        fin;
  logic [1:0]  cnt;
  logic [97:0] acc;
  logic [24:0] pa;
  logic [24:0] pb;
  logic [49:0] pp;
  logic [97:0] pp_sh;
  logic [65:0] q;

  always_comb begin
    pa = cnt[0] ? {1'b0, ua[48:25]} : ua[24:0];
    pb = cnt[1] ? {1'b0, ub[48:25]} : ub[24:0];
    pp = 50'(pa) * 50'(pb);
    case (cnt)
      2'd0:    pp_sh = 98'(pp);
      2'd3:    pp_sh = 98'(pp) << 50;
      default: pp_sh = 98'(pp) << 25;
    endcase
    // floor toward minus infinity on the signed value
    q = acc[97:32] + 66'(neg && (acc[31:0] != 32'd0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= fin;
      fin  <= busy && (cnt == 2'd3);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd3) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua  <= stsc_pkg::mag(a);
      ub  <= stsc_pkg::mag(b);
      neg <= a[49] ^ b[49];
      acc <= '0;
    end else if (busy) begin
      acc <= acc + pp_sh;
    end
    if (fin) begin
      res <= stsc_pkg::mag_sat(q, neg);
    end
  end

endmodule

// ----- design/stsc_div.sv -----
// ----------------------------------------------------------------------------
// stsc_div
// Q16.32 divider: radix-2 restoring, one quotient bit a cycle, truncating.
// ----------------------------------------------------------------------------
module stsc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  stsc_pkg::opnd_t a,
  input  stsc_pkg::opnd_t b,
  output logic            done,
  output stsc_pkg::fx_t   res
);

  logic [48:0] un_s;
  logic [48:0] ud_s;
  logic        neg_s;
  logic        sp_zero;
  logic        sp_div0;
  logic        sp_ovf;
  logic        busy;
  logic [5:0]  cnt;
  logic        neg;
  logic [48:0] ud;
  logic [48:0] r;
  logic [46:0] dsh;
  logic [46:0] q;
  logic [49:0] tr;
  logic        ge;
  logic [48:0] r_n;
  logic [46:0] q_n;

  always_comb begin
    un_s    = stsc_pkg::mag(a);
    ud_s    = stsc_pkg::mag(b);
    neg_s   = a[49] ^ b[49];
    sp_zero = (un_s == 49'd0);
    sp_div0 = (ud_s == 49'd0);
    // quotient would reach 2^47: saturate
    sp_ovf  = ({15'd0, un_s} >= {ud_s, 15'd0});
    tr      = {r, dsh[46]};
    ge      = (tr >= {1'b0, ud});
    r_n     = ge ? 49'(tr - {1'b0, ud}) : tr[48:0];
    q_n     = {q[45:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 6'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 6'd0;
        if (sp_zero || sp_div0 || sp_ovf) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd46) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= neg_s;
      ud  <= ud_s;
      r   <= {15'd0, un_s[48:15]};
      dsh <= {un_s[14:0], 32'd0};
      q   <= '0;
      if (sp_zero) begin
        res <= '0;
      end else if (sp_div0) begin
        res <= a[49] ? stsc_pkg::FX_MIN : stsc_pkg::FX_MAX;
      end else if (sp_ovf) begin
        res <= neg_s ? stsc_pkg::FX_MIN : stsc_pkg::FX_MAX;
      end
    end else if (busy) begin
      r   <= r_n;
      dsh <= dsh << 1;
      q   <= q_n;
      if (cnt == 6'd46) begin
        res <= neg ? 48'(-{1'b0, q_n}) : 48'({1'b0, q_n});
      end
    end
  end

endmodule

// ----- design/stsc_back.sv -----
// ----------------------------------------------------------------------------
// stsc_back
// Sequencer that runs one cell through the shared multiplier and divider,
// keeps the edge flux and holds the result register.
// ----------------------------------------------------------------------------
module stsc_back (
  input  logic            clk,
  input  logic            rst,
  input  stsc_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  stsc_pkg::cell_t q_item,
  output logic            q_pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [143:0]    m_axis_tdata
);

  stsc_pkg::bk_state_t state;
  stsc_pkg::bk_state_t state_next;
  stsc_pkg::step_t     step;
  stsc_pkg::cell_t     cur;
  stsc_pkg::fx_t       e;
  stsc_pkg::fx_t       res [0:stsc_pkg::NumSteps-1];
  stsc_pkg::fx_t       out_psi;
  stsc_pkg::fx_t       out_scal;
  stsc_pkg::fx_t       out_hout;
  logic                out_valid;
  logic                out_load;

  stsc_pkg::opnd_t     op_a;
  stsc_pkg::opnd_t     op_b;
  logic                use_div;
  logic                mul_start;
  logic                div_start;
  logic                mul_done;
  logic                div_done;
  stsc_pkg::fx_t       mul_res;
  stsc_pkg::fx_t       div_res;

  stsc_pkg::opnd_t     amu;
  stsc_pkg::opnd_t     diff;
  stsc_pkg::opnd_t     onemt;
  stsc_pkg::fx_t       sum;
  stsc_pkg::fx_t       asum;
  stsc_pkg::fx_t       ar;
  stsc_pkg::fx_t       num;
  stsc_pkg::fx_t       den;
  stsc_pkg::fx_t       dh;
  stsc_pkg::fx_t       scal;
  stsc_pkg::fx_t       e_next;
  stsc_pkg::fx_t       hout;

  always_comb begin
    // widen before negating so the most negative cosine keeps its magnitude
    amu   = cfg.direction_cosine[33] ? -stsc_pkg::opnd_t'(cfg.direction_cosine)
                                     : stsc_pkg::opnd_t'(cfg.direction_cosine);
    diff  = $signed({3'd0, cur.area_outer}) - $signed({3'd0, cur.area_inner});
    onemt = 50'sh1_0000_0000 - $signed({17'd0, cfg.corrector_tau});
    sum   = stsc_pkg::sat_fx($signed({5'd0, cur.area_outer})
                             + $signed({5'd0, cur.area_inner}));
    asum  = stsc_pkg::sat_fx(stsc_pkg::sx(cfg.alpha_upper)
                             + stsc_pkg::sx(cfg.alpha_lower));
    // outward form uses the outer area, inward the inner
    ar    = cfg.direction_cosine[33] ? {1'b0, cur.area_inner} : {1'b0, cur.area_outer};
    num   = stsc_pkg::sat_fx(stsc_pkg::sx(res[stsc_pkg::ST_M2])
                             + stsc_pkg::sx(res[stsc_pkg::ST_M4])
                             + stsc_pkg::sx(cur.cell_source));
    den   = stsc_pkg::sat_fx((stsc_pkg::sx(res[stsc_pkg::ST_M5]) <<< 1)
                             + (stsc_pkg::sx(res[stsc_pkg::ST_M6]) <<< 1)
                             + stsc_pkg::sx(cur.cell_total));
    dh    = stsc_pkg::sat_fx(stsc_pkg::sx(res[stsc_pkg::ST_PSI])
                             - stsc_pkg::sx(res[stsc_pkg::ST_M8]));
    scal  = stsc_pkg::sat_fx(stsc_pkg::sx(cur.scalar_flux_in)
                             + stsc_pkg::sx(res[stsc_pkg::ST_M7]));
    e_next = stsc_pkg::sat_fx((stsc_pkg::sx(res[stsc_pkg::ST_PSI]) <<< 1)
                              - stsc_pkg::sx(e));
    hout  = cur.cell_is_origin ? cur.angle_half_in : res[stsc_pkg::ST_HQ];
  end

  // operand routing per step
  always_comb begin
    use_div = 1'b0;
    op_a    = '0;
    op_b    = '0;
    case (step)
      stsc_pkg::ST_G: begin
        use_div = 1'b1;
        op_a    = diff;
        op_b    = $signed({15'd0, cfg.quad_weight});
      end
      stsc_pkg::ST_M1: begin
        op_a = amu;
        op_b = stsc_pkg::wide(sum);
      end
      stsc_pkg::ST_M2: begin
        op_a = stsc_pkg::wide(res[stsc_pkg::ST_M1]);
        op_b = stsc_pkg::wide(e);
      end
      stsc_pkg::ST_M3: begin
        op_a = stsc_pkg::wide(res[stsc_pkg::ST_G]);
        op_b = stsc_pkg::wide(asum);
      end
      stsc_pkg::ST_M4: begin
        op_a = stsc_pkg::wide(res[stsc_pkg::ST_M3]);
        op_b = stsc_pkg::wide(cur.angle_half_in);
      end
      stsc_pkg::ST_M5: begin
        op_a = amu;
        op_b = stsc_pkg::wide(ar);
      end
      stsc_pkg::ST_M6: begin
        op_a = stsc_pkg::wide(res[stsc_pkg::ST_G]);
        op_b = stsc_pkg::wide(cfg.alpha_upper);
      end
      stsc_pkg::ST_PSI: begin
        use_div = 1'b1;
        op_a    = stsc_pkg::wide(num);
        op_b    = stsc_pkg::wide(den);
      end
      stsc_pkg::ST_M7: begin
        op_a = $signed({15'd0, cfg.quad_weight});
        op_b = stsc_pkg::wide(res[stsc_pkg::ST_PSI]);
      end
      stsc_pkg::ST_M8: begin
        op_a = onemt;
        op_b = stsc_pkg::wide(cur.angle_half_in);
      end
      stsc_pkg::ST_HQ: begin
        use_div = 1'b1;
        op_a    = stsc_pkg::wide(dh);
        op_b    = $signed({17'd0, cfg.corrector_tau});
      end
      default: begin
        use_div = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      stsc_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_item.skip ? stsc_pkg::BK_IDLE : stsc_pkg::BK_ISSUE;
        end
      end
      stsc_pkg::BK_ISSUE: begin
        mul_start  = ~use_div;
        div_start  = use_div;
        state_next = stsc_pkg::BK_WAIT;
      end
      stsc_pkg::BK_WAIT: begin
        if (mul_done || div_done) begin
          state_next = (step == stsc_pkg::ST_HQ) ? stsc_pkg::BK_FIN
                                                 : stsc_pkg::BK_ISSUE;
        end
      end
      stsc_pkg::BK_FIN: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = stsc_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = stsc_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stsc_pkg::BK_IDLE;
      out_valid <= 1'b0;
      e         <= '0;
      step      <= stsc_pkg::ST_G;
    end else begin
      state     <= state_next;
      out_valid <= out_load | (out_valid & ~m_axis_tready);
      if (q_pop) begin
        step <= stsc_pkg::ST_G;
        if (q_item.start_of_sweep) begin
          e <= cfg.edge_flux_start;
        end
      end else if (state == stsc_pkg::BK_WAIT && (mul_done || div_done)
                   && step != stsc_pkg::ST_HQ) begin
        step <= stsc_pkg::step_t'(step + 4'd1);
      end
      if (out_load) begin
        e <= e_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == stsc_pkg::BK_WAIT && (mul_done || div_done)) begin
      res[step] <= mul_done ? mul_res : div_res;
    end
    if (out_load) begin
      out_psi  <= res[stsc_pkg::ST_PSI];
      out_scal <= scal;
      out_hout <= hout;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_hout, out_scal, out_psi};

  stsc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  stsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (op_a),
    .b     (op_b),
    .done  (div_done),
    .res   (div_res)
  );

endmodule

// ----- design/stsc_checker.sv -----
// ----------------------------------------------------------------------------
// stsc_checker
// Port-level checks for the sweep cell, bound to the top level.
// ----------------------------------------------------------------------------
module stsc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [143:0] m_axis_tdata
);

  // reset empties the queue and drops any pending result
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && s_axis_tready))
    else $error("state not cleared by reset");

  // no cell can finish straight after reset release
  a_no_early_result: assert property (@(posedge clk)
    rst ##1 1'b1 |=> !m_axis_tvalid)
    else $error("result too soon after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind spherical_transport_sweep_cell_top stsc_checker u_stsc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- test/tb_spherical_transport_sweep_cell_top.sv -----
// ----------------------------------------------------------------------------
// tb_spherical_transport_sweep_cell_top
// Self-checking bench for the spherical sweep cell. Cell items are streamed
// in with random gaps. Each accepted cell is run through a bit-exact Q16.32
// model of the diamond-difference and corrector math. Results are checked in
// order against it, while the register settings change between phases.
// ----------------------------------------------------------------------------
module tb_spherical_transport_sweep_cell_top;

  localparam longint SatHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SatLo = -64'sh0000_8000_0000_0000;
  localparam longint FxOne = 64'sh1_0000_0000;
  localparam logic [47:0] FxMax = stsc_pkg::FX_MAX;
  localparam logic [47:0] FxMin = stsc_pkg::FX_MIN;
  localparam int DrainCycles = 400;
  localparam int WatchdogLimit = 20000;

  typedef struct {
    bit          sos;
    bit          origin;
    logic [46:0] ao;
    logic [46:0] ai;
    logic [47:0] src;
    logic [47:0] tot;
    logic [47:0] half;
    logic [47:0] phi;
  } cell_item_t;

  typedef struct {
    logic [47:0] psi;
    logic [47:0] scal;
    logic [47:0] half;
  } flux_result_t;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;
  logic         cfg_we;
  logic [stsc_pkg::CfgAddrWidth-1:0] cfg_addr;
  logic [stsc_pkg::CfgDataWidth-1:0] cfg_data;

  spherical_transport_sweep_cell_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data)
  );

  // bench copy of the registers and of the running edge flux
  logic [34:0]        w_reg;
  logic signed [33:0] mu_reg;
  logic signed [47:0] au_reg, al_reg, e0_reg;
  logic [32:0]        tau_reg;
  longint             edge_acc;

  cell_item_t   pending_cells[$];
  flux_result_t expected_flux[$];

  int errors;
  int cells_sent;
  int results_seen;
  int phases_run;
  int idle_cycles;
  int src_gap;
  int sink_stall;
  bit no_idle;        // set for whole phases: back-to-back traffic

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- fixed-point model ----------------
  function automatic longint sat_wide(input logic signed [127:0] x);
    if (x > 128'(SatHi)) return SatHi;
    if (x < 128'(SatLo)) return SatLo;
    return longint'(x);
  endfunction

  // floor(a*b / 2^32), saturated
  function automatic longint fx_mul(input longint a, input longint b);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = pa * pb;
    return sat_wide(p >>> 32);
  endfunction

  // trunc(n*2^32 / d), saturated; zero divisor gives the signed extreme
  function automatic longint fx_div(input longint n, input longint d);
    logic [127:0] un, ud, q;
    if (n == 0) return 0;
    if (d == 0) return (n < 0) ? SatLo : SatHi;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = (un << 32) / ud;
    if ((n < 0) != (d < 0)) begin
      if (q > 128'h8000_0000_0000) return SatLo;
      return -longint'(q);
    end
    if (q > 128'(SatHi)) return SatHi;
    return longint'(q);
  endfunction

  function automatic longint sat48(input longint x);
    if (x > SatHi) return SatHi;
    if (x < SatLo) return SatLo;
    return x;
  endfunction

  // one sweep step; returns 1 when the cell yields a result
  function automatic bit sweep_cell_flux(input cell_item_t c, output flux_result_t r);
    longint w, tau, mu, amu, au, al, ao, ai, s, t, h, phi;
    longint g, num, den, psi, hout;
    w = longint'(w_reg);
    tau = longint'(tau_reg);
    mu = longint'(mu_reg);
    au = longint'(au_reg);
    al = longint'(al_reg);
    ao = longint'(c.ao);
    ai = longint'(c.ai);
    s = longint'($signed(c.src));
    t = longint'($signed(c.tot));
    h = longint'($signed(c.half));
    phi = longint'($signed(c.phi));
    r = '{default: '0};
    // the seed load happens even for a zero cosine
    if (c.sos) edge_acc = longint'(e0_reg);
    if (mu == 0) return 1'b0;
    amu = (mu < 0) ? -mu : mu;
    g = fx_div(ao - ai, w);
    num = sat48(fx_mul(fx_mul(amu, sat48(ao + ai)), edge_acc)
                + fx_mul(fx_mul(g, sat48(au + al)), h) + s);
    den = sat48(2 * fx_mul(amu, (mu > 0) ? ao : ai) + 2 * fx_mul(g, au) + t);
    psi = fx_div(num, den);
    r.psi = psi[47:0];
    r.scal = 48'(sat48(phi + fx_mul(w, psi)));
    edge_acc = sat48(2 * psi - edge_acc);
    // origin cell passes its angle-half flux straight through
    if (c.origin) hout = h;
    else hout = fx_div(sat48(psi - fx_mul(FxOne - tau, h)), tau);
    r.half = hout[47:0];
    return 1'b1;
  endfunction

  // ---------------- random values ----------------
  function automatic logic [63:0] rand_bits(input int n);
    logic [63:0] v;
    v = {$urandom, $urandom};
    return (n >= 64) ? v : (v & ((64'd1 << n) - 1));
  endfunction

  // signed value of up to n bits magnitude, sign extended to 48 bits
  function automatic logic [47:0] rand_signed(input int n);
    logic [63:0] v;
    v = rand_bits(n);
    return ($urandom_range(0, 1) != 0) ? 48'(-v) : v[47:0];
  endfunction

  function automatic int pick_gap();
    int sel;
    if (no_idle) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // ---------------- stimulus helpers ----------------
  task automatic push_cell(input bit sos, input bit org, input logic [46:0] ao,
                           input logic [46:0] ai, input logic [47:0] s,
                           input logic [47:0] t, input logic [47:0] h,
                           input logic [47:0] phi);
    cell_item_t c;
    c.sos = sos; c.origin = org;
    c.ao = ao; c.ai = ai; c.src = s; c.tot = t; c.half = h; c.phi = phi;
    pending_cells.push_back(c);
  endtask

  // one sweep of n cells: outward from the origin, or inward ending there
  task automatic push_sweep(input int n);
    bit inward;
    bit org;
    int k;
    logic [46:0] a_lo, a_hi;
    inward = bit'($urandom_range(0, 1));
    for (k = 0; k < n; k++) begin
      a_lo = 47'(rand_bits($urandom_range(20, 38)));
      a_hi = a_lo + 47'(rand_bits($urandom_range(16, 36)));
      org = inward ? (k == n - 1) : (k == 0);
      push_cell(k == 0, org, a_hi, org ? 47'd0 : a_lo,
                rand_signed($urandom_range(16, 38)),
                48'(rand_bits($urandom_range(24, 40))),
                rand_signed($urandom_range(16, 38)), rand_signed($urandom_range(16, 40)));
    end
  endtask

  // raw item: every bit of every field at random
  task automatic push_noise();
    push_cell(bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
              47'(rand_bits(47)), 47'(rand_bits(47)),
              48'(rand_bits(48)), 48'(rand_bits(48)), 48'(rand_bits(48)),
              48'(rand_bits(48)));
  endtask

  task automatic push_random(input int count);
    int sent;
    int n;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        n = $urandom_range(1, 12);
        push_sweep(n);
        sent += n;
      end else begin
        push_noise();
        sent++;
      end
    end
  endtask

  task automatic write_reg(input stsc_pkg::cfg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val[47:0];
    case (idx)
      stsc_pkg::CFG_QUAD_WEIGHT:     w_reg = val[34:0];
      stsc_pkg::CFG_DIRECTION_COS:   mu_reg = val[33:0];
      stsc_pkg::CFG_ALPHA_UPPER:     au_reg = val[47:0];
      stsc_pkg::CFG_ALPHA_LOWER:     al_reg = val[47:0];
      stsc_pkg::CFG_CORRECTOR_TAU:   tau_reg = val[32:0];
      stsc_pkg::CFG_EDGE_FLUX_START: e0_reg = val[47:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [63:0] w, input logic [63:0] mu,
                           input logic [63:0] au, input logic [63:0] al,
                           input logic [63:0] tau, input logic [63:0] e0);
    write_reg(stsc_pkg::CFG_QUAD_WEIGHT, w);
    write_reg(stsc_pkg::CFG_DIRECTION_COS, mu);
    write_reg(stsc_pkg::CFG_ALPHA_UPPER, au);
    write_reg(stsc_pkg::CFG_ALPHA_LOWER, al);
    write_reg(stsc_pkg::CFG_CORRECTOR_TAU, tau);
    write_reg(stsc_pkg::CFG_EDGE_FLUX_START, e0);
  endtask

  // sender holds off until everything is out; also the only point where
  // registers may change. Zero-cosine cells give no result, so drain extra.
  task automatic wait_drained();
    wait (pending_cells.size() == 0 && !s_axis_tvalid && expected_flux.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    phases_run++;
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    cell_item_t c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_cells.size() != 0) begin
        c = pending_cells.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, c.phi, c.half, c.tot, c.src, c.ai, c.ao};
        s_axis_tuser <= {c.origin, c.sos};
        src_gap = pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall = 0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_stall = pick_gap();
    end
  end

  // ---------------- monitor / scoreboard ----------------
  always @(posedge clk) begin
    cell_item_t   c;
    flux_result_t r;
    flux_result_t exp_r;
    if (!rst) begin
      idle_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        idle_cycles = 0;
        cells_sent++;
        c.ao = s_axis_tdata[46:0];
        c.ai = s_axis_tdata[93:47];
        c.src = s_axis_tdata[141:94];
        c.tot = s_axis_tdata[189:142];
        c.half = s_axis_tdata[237:190];
        c.phi = s_axis_tdata[285:238];
        c.sos = s_axis_tuser[0];
        c.origin = s_axis_tuser[1];
        if (sweep_cell_flux(c, r)) expected_flux.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        idle_cycles = 0;
        results_seen++;
        if (expected_flux.size() == 0) begin
          errors++;
          $display("%0t: unexpected result item %h", $time, m_axis_tdata);
        end else begin
          exp_r = expected_flux.pop_front();
          if (m_axis_tdata[47:0] !== exp_r.psi) begin
            errors++;
            $display("%0t: angular_flux expected %h actual %h", $time, exp_r.psi,
                     m_axis_tdata[47:0]);
          end
          if (m_axis_tdata[95:48] !== exp_r.scal) begin
            errors++;
            $display("%0t: scalar_flux_out expected %h actual %h", $time, exp_r.scal,
                     m_axis_tdata[95:48]);
          end
          if (m_axis_tdata[143:96] !== exp_r.half) begin
            errors++;
            $display("%0t: angle_half_out expected %h actual %h", $time, exp_r.half,
                     m_axis_tdata[143:96]);
          end
        end
      end
    end
  end

  // watchdog: no item moving on either side for too long
  always @(posedge clk) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, %0d results still expected", $time, expected_flux.size());
      $display("spherical_transport_sweep_cell_top verification failed");
      $finish;
    end
  end

  // ---------------- test sequence ----------------
  initial begin
    int p;
    phases_run = 0;
    no_idle = 1'b0;
    w_reg = 35'h1_0000_0000;
    mu_reg = 34'sh1_0000_0000;
    au_reg = '0; al_reg = '0; e0_reg = '0;
    tau_reg = 33'h0_8000_0000;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    push_cell(1, 1, 47'h1_0000_0000, 47'd0, 48'h1_0000_0000, 48'h1_0000_0000,
              48'h8000_0000, 48'd0);
    push_cell(0, 0, 47'h2_0000_0000, 47'h1_0000_0000, 48'h1_0000_0000,
              48'h2_0000_0000, 48'h4000_0000, 48'h1_0000_0000);
    push_cell(0, 0, 47'd0, 47'd0, 48'd0, 48'd0, 48'd0, 48'd0);           // 0/0
    push_cell(0, 0, 47'd0, 47'd0, 48'h1_0000_0000, 48'd0, 48'd0, 48'd0); // zero den
    push_cell(0, 0, 47'd0, 47'd0, FxMin, 48'd0, 48'd0, FxMax);
    push_cell(1, 0, {47{1'b1}}, {47{1'b1}}, FxMax, FxMax, FxMax, FxMax);
    push_cell(0, 1, {47{1'b1}}, 47'd0, FxMin, FxMin, FxMin, FxMin);
    push_cell(0, 0, 47'd0, {47{1'b1}}, FxMax, FxMin, FxMin, FxMax);
    push_cell(0, 0, 47'd1, 47'd1, 48'd1, 48'd1, {48{1'b1}}, {48{1'b1}});
    push_cell(1, 1, 47'h3_0000_0000, 47'h1_0000_0000, 48'h5_0000_0000,
              48'h3_0000_0000, 48'h2_0000_0000, 48'h1_0000_0000);
    wait_drained();

    // high extremes of every register
    write_all(64'h7_FFFF_FFFF, 64'h1_0000_0000, 64'h7FFF_FFFF_FFFF,
              64'h7FFF_FFFF_FFFF, 64'h1_0000_0000, 64'h7FFF_FFFF_FFFF);
    push_cell(1, 0, 47'h1_0000_0000, 47'h8000_0000, 48'h1_0000_0000, 48'h1_0000_0000,
              48'h1_0000_0000, 48'd0);
    push_cell(0, 0, {47{1'b1}}, 47'd0, FxMax, FxMax, FxMin, FxMax);
    push_cell(0, 1, 47'h10, 47'h20, FxMin, 48'd5, FxMax, FxMin);
    wait_drained();

    // low extremes: negative cosine selects the inward form
    write_all(64'd1, 64'h3_0000_0000, 64'h8000_0000_0000, 64'h8000_0000_0000,
              64'd1, 64'h8000_0000_0000);
    push_cell(1, 0, 47'h1_0000_0000, 47'h2_0000_0000, 48'h1_0000_0000, 48'h3_0000_0000,
              48'h1_0000_0000, 48'h1_0000_0000);
    push_cell(0, 0, 47'd0, {47{1'b1}}, FxMin, FxMin, FxMax, FxMin);
    push_cell(0, 1, 47'h100, 47'h100, 48'd7, FxMax, FxMin, FxMax);
    wait_drained();

    // zero cosine: seed loads still happen, no results; then zero w and tau
    write_all(64'h1_0000_0000, 64'd0, 64'h1_0000_0000, 64'h8000_0000, 64'h8000_0000,
              64'h2_0000_0000);
    push_cell(1, 0, 47'h1_0000_0000, 47'd0, 48'h1_0000_0000, 48'h1_0000_0000, 48'd1, 48'd2);
    push_cell(0, 1, 47'h1_0000_0000, 47'd0, 48'h1_0000_0000, 48'h1_0000_0000, 48'd1, 48'd2);
    push_noise();
    wait_drained();
    write_reg(stsc_pkg::CFG_DIRECTION_COS, 64'h1_0000_0000);
    write_reg(stsc_pkg::CFG_QUAD_WEIGHT, 64'd0);
    write_reg(stsc_pkg::CFG_CORRECTOR_TAU, 64'd0);
    push_cell(0, 0, 47'h2_0000_0000, 47'h1_0000_0000, 48'h1_0000_0000,
              48'h1_0000_0000, 48'h1_0000_0000, 48'd0);
    push_cell(0, 0, 47'd0, 47'd0, 48'd0, 48'd1, 48'd0, 48'd0);
    wait_drained();

    // random phases, each with its own register setting
    for (p = 0; p < 7; p++) begin
      no_idle = (p == 2);
      if (p == 5) begin
        // out-of-range cosine and a wide-open weight
        write_all(rand_bits(35), 64'h2_0000_0000, rand_bits(48), rand_bits(48),
                  rand_bits(33), rand_bits(48));
      end else begin
        write_all(64'h4000_0000 + rand_bits(34),
                  ($urandom_range(0, 1) ? 64'h0 : -64'h1) ^ rand_bits(32),
                  rand_signed($urandom_range(20, 36)), rand_signed($urandom_range(20, 36)),
                  64'h1000_0000 + rand_bits(32), rand_signed($urandom_range(20, 40)));
        if (mu_reg == 0) write_reg(stsc_pkg::CFG_DIRECTION_COS, 64'h8000_0000);
      end
      push_random(130);
      wait_drained();
    end

    $display("run covered %0d cells in %0d phases, %0d results checked",
             cells_sent, phases_run, results_seen);
    $display("extreme, zero-cosine, zero-divisor and random register settings exercised");
    if (errors == 0) begin
      $display("spherical_transport_sweep_cell_top verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("spherical_transport_sweep_cell_top verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/stsc_pkg.sv
design/stsc_front.sv
design/stsc_mul.sv
design/stsc_div.sv
design/stsc_back.sv
design/spherical_transport_sweep_cell_top.sv
design/stsc_checker.sv
test/tb_spherical_transport_sweep_cell_top.sv
